### hw/rtl/hsv_to_rgb_converter_top_defines.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Clocked checks on clk_i; they compile away when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// check that is ignored while reset is asserted
`define HSV_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("hsv_to_rgb_converter_top: check failed");
// check that also holds during reset
`define HSV_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk_i) prop) \
    else $error("hsv_to_rgb_converter_top: check failed");
`else
`define HSV_ASSERT(label, prop)
`define HSV_ASSERT_ALWAYS(label, prop)
`endif

`endif

### hw/rtl/hsv_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared item type, sector codes, queue status and fixed-point constants.
// ----------------------------------------------------------------------------
`default_nettype none

package hsv_pkg;

  // One 60 degree sector in 1/64 degree hue units
  localparam logic [11:0] SectorUnits = 12'd3840;
  // 255 * 3840, full scale of saturation times fraction
  localparam logic [19:0] FracScale   = 20'd979200;
  // Full scale of an 8-bit unit value
  localparam logic [7:0]  UnitMax     = 8'd255;

  typedef enum logic [2:0] {
    SECTOR_0,
    SECTOR_1,
    SECTOR_2,
    SECTOR_3,
    SECTOR_4,
    SECTOR_5
  } sector_e;

  // Classified color handed from the front end to the datapath
  typedef struct packed {
    sector_e     sector;
    logic [11:0] frac;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic        grey;
  } hsv_item_t;

  // Queue fill status
  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

### hw/rtl/hsv_front.sv
// ----------------------------------------------------------------------------
// HSV front end
// Accepts one color per beat, wraps the hue, splits it into sector and
// fraction, flags grey, and holds the result in a single register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_front import hsv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire logic [14:0] hue_i,
  input  wire logic [7:0]  saturation_i,
  input  wire logic [7:0]  brightness_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      hsv_item_t   out_item_o
);

  localparam logic [14:0] FullTurn = 15'd23040;
  localparam logic [14:0] Base1    = 15'd3840;
  localparam logic [14:0] Base2    = 15'd7680;
  localparam logic [14:0] Base3    = 15'd11520;
  localparam logic [14:0] Base4    = 15'd15360;
  localparam logic [14:0] Base5    = 15'd19200;

  logic        valid_q, valid_d;
  hsv_item_t   item_q, item_d;
  logic [14:0] hue_wrap;
  logic [14:0] base;
  logic [14:0] frac_full;
  sector_e     sector;

  // Fold hue beyond a full turn back into range
  assign hue_wrap = (hue_i >= FullTurn) ? (hue_i - FullTurn) : hue_i;

  // Pick the sector by comparing against the sector boundaries
  always_comb begin
    priority if (hue_wrap >= Base5) begin
      sector = SECTOR_5;
      base   = Base5;
    end else if (hue_wrap >= Base4) begin
      sector = SECTOR_4;
      base   = Base4;
    end else if (hue_wrap >= Base3) begin
      sector = SECTOR_3;
      base   = Base3;
    end else if (hue_wrap >= Base2) begin
      sector = SECTOR_2;
      base   = Base2;
    end else if (hue_wrap >= Base1) begin
      sector = SECTOR_1;
      base   = Base1;
    end else begin
      sector = SECTOR_0;
      base   = '0;
    end
  end

  assign frac_full = hue_wrap - base;

  // Build the classified item
  always_comb begin
    item_d.sector = sector;
    item_d.frac   = frac_full[11:0];
    item_d.sat    = saturation_i;
    item_d.val    = brightness_i;
    item_d.grey   = (saturation_i == '0);
  end

  // Take a new beat when the stage is empty or draining
  assign in_ready_o = !valid_q || out_ready_i;

  always_comb begin
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Hold the payload until it moves on
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      item_q <= item_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

`default_nettype wire

### hw/rtl/hsv_fifo.sv
// ----------------------------------------------------------------------------
// HSV item queue
// Small register queue that decouples the front end from the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_fifo import hsv_pkg::*; #(
  parameter int unsigned Depth = 2
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output      logic         in_ready_o,
  input  wire hsv_item_t    in_item_i,
  output      logic         out_valid_o,
  input  wire logic         out_ready_i,
  output      hsv_item_t    out_item_o,
  output      fifo_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr  = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt  = CntW'(Depth);

  hsv_item_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);

  assign in_ready_o  = !status_o.full;
  assign out_valid_o = !status_o.empty;
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : (wr_ptr_q + 1'b1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : (rd_ptr_q + 1'b1);
    end
    unique case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the pushed beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

  assign out_item_o = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

### hw/rtl/hsv_back.sv
// ----------------------------------------------------------------------------
// HSV datapath
// Five-stage pipeline: products, scaled products, reciprocal estimate,
// correction, and final divide with channel routing into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hsv_back import hsv_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output      logic        in_ready_o,
  input  wire hsv_item_t   in_item_i,
  output      logic        out_valid_o,
  input  wire logic        out_ready_i,
  output      logic [7:0]  red_o,
  output      logic [7:0]  green_o,
  output      logic [7:0]  blue_o
);

  localparam int unsigned NumStages    = 5;
  // floor(2^24 / 15), underestimates a quotient by at most one
  localparam logic [20:0] RecipFifteen = 21'd1118481;
  localparam logic [19:0] Fifteen      = 20'd15;

  // Exact floor(x / 255) for x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'd1 + 17'(x[15:8]);
    return s[15:8];
  endfunction

  logic [NumStages-1:0] valid_q, valid_d;
  logic [NumStages-1:0] adv;

  // Stage 1
  logic [19:0] s1_prod_q_q, s1_prod_t_q;
  logic [15:0] s1_prod_p_q;
  logic [7:0]  s1_val_q;
  sector_e     s1_sector_q;
  logic        s1_grey_q;
  logic [11:0] frac_inv;

  // Stage 2
  logic [27:0] s2_x_q_q, s2_x_t_q;
  logic [7:0]  s2_p_q;
  logic [7:0]  s2_val_q;
  sector_e     s2_sector_q;
  logic        s2_grey_q;

  // Stage 3
  logic [40:0] mul_q, mul_t;
  logic [15:0] s3_est_q_q, s3_est_t_q;
  logic [19:0] s3_y_q_q, s3_y_t_q;
  logic [7:0]  s3_p_q;
  logic [7:0]  s3_val_q;
  sector_e     s3_sector_q;
  logic        s3_grey_q;

  // Stage 4
  logic [19:0] rem_q, rem_t;
  logic [15:0] s4_z_q_q, s4_z_t_q;
  logic [7:0]  s4_p_q;
  logic [7:0]  s4_val_q;
  sector_e     s4_sector_q;
  logic        s4_grey_q;

  // Output stage
  logic [7:0]  q_val, t_val;
  logic [7:0]  red_d, green_d, blue_d;
  logic [7:0]  red_q, green_q, blue_q;

  // Stage can load when empty or when its successor moves
  always_comb begin
    adv[NumStages-1] = !valid_q[NumStages-1] || out_ready_i;
    for (int i = NumStages - 2; i >= 0; i--) begin
      adv[i] = !valid_q[i] || adv[i+1];
    end
  end

  assign in_ready_o = adv[0];

  always_comb begin
    valid_d[0] = adv[0] ? in_valid_i : valid_q[0];
    for (int i = 1; i < NumStages; i++) begin
      valid_d[i] = adv[i] ? valid_q[i-1] : valid_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Stage 1: saturation times fraction and its complement, value times 1-S
  assign frac_inv = SectorUnits - in_item_i.frac;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_prod_q_q <= 20'(in_item_i.sat * in_item_i.frac);
      s1_prod_t_q <= 20'(in_item_i.sat * frac_inv);
      s1_prod_p_q <= 16'(in_item_i.val * (UnitMax - in_item_i.sat));
      s1_val_q    <= in_item_i.val;
      s1_sector_q <= in_item_i.sector;
      s1_grey_q   <= in_item_i.grey;
    end
  end

  // Stage 2: scale by value, finish p
  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      s2_x_q_q    <= 28'(s1_val_q * (FracScale - s1_prod_q_q));
      s2_x_t_q    <= 28'(s1_val_q * (FracScale - s1_prod_t_q));
      s2_p_q      <= div255(s1_prod_p_q);
      s2_val_q    <= s1_val_q;
      s2_sector_q <= s1_sector_q;
      s2_grey_q   <= s1_grey_q;
    end
  end

  // Stage 3: estimate (x / 256) / 15 by reciprocal
  assign mul_q = 41'(s2_x_q_q[27:8] * RecipFifteen);
  assign mul_t = 41'(s2_x_t_q[27:8] * RecipFifteen);

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      s3_est_q_q  <= mul_q[39:24];
      s3_est_t_q  <= mul_t[39:24];
      s3_y_q_q    <= s2_x_q_q[27:8];
      s3_y_t_q    <= s2_x_t_q[27:8];
      s3_p_q      <= s2_p_q;
      s3_val_q    <= s2_val_q;
      s3_sector_q <= s2_sector_q;
      s3_grey_q   <= s2_grey_q;
    end
  end

  // Stage 4: correct the estimate by one where the remainder overflows
  assign rem_q = s3_y_q_q - ({s3_est_q_q, 4'b0000} - 20'(s3_est_q_q));
  assign rem_t = s3_y_t_q - ({s3_est_t_q, 4'b0000} - 20'(s3_est_t_q));

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      s4_z_q_q    <= (rem_q >= Fifteen) ? (s3_est_q_q + 1'b1) : s3_est_q_q;
      s4_z_t_q    <= (rem_t >= Fifteen) ? (s3_est_t_q + 1'b1) : s3_est_t_q;
      s4_p_q      <= s3_p_q;
      s4_val_q    <= s3_val_q;
      s4_sector_q <= s3_sector_q;
      s4_grey_q   <= s3_grey_q;
    end
  end

  // Output stage: final divide by 255, route by sector, grey copies the value
  assign q_val = div255(s4_z_q_q);
  assign t_val = div255(s4_z_t_q);

  always_comb begin
    if (s4_grey_q) begin
      red_d   = s4_val_q;
      green_d = s4_val_q;
      blue_d  = s4_val_q;
    end else begin
      unique case (s4_sector_q)
        SECTOR_0: begin
          red_d = s4_val_q; green_d = t_val;    blue_d = s4_p_q;
        end
        SECTOR_1: begin
          red_d = q_val;    green_d = s4_val_q; blue_d = s4_p_q;
        end
        SECTOR_2: begin
          red_d = s4_p_q;   green_d = s4_val_q; blue_d = t_val;
        end
        SECTOR_3: begin
          red_d = s4_p_q;   green_d = q_val;    blue_d = s4_val_q;
        end
        SECTOR_4: begin
          red_d = t_val;    green_d = s4_p_q;   blue_d = s4_val_q;
        end
        SECTOR_5: begin
          red_d = s4_val_q; green_d = s4_p_q;   blue_d = q_val;
        end
        default: begin
          red_d = s4_val_q; green_d = s4_p_q;   blue_d = q_val;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign out_valid_o = valid_q[NumStages-1];
  assign red_o       = red_q;
  assign green_o     = green_q;
  assign blue_o      = blue_q;

endmodule

`default_nettype wire

### hw/rtl/hsv_to_rgb_converter_top.sv
// Path from input beat to output beat: 1 front register, 1 queue slot and
//   5 datapath stages. Throughput: one color per clock while the output is
//   not stalled; set by the single-issue datapath pipeline.
// The queue lets the front end keep accepting while the output is stalled.
// Reset (rst_ni low, asynchronous) empties all stages and the queue;
//   no clearing pass, input is taken in the first cycle after reset.
`default_nettype none

`include "hsv_to_rgb_converter_top_defines.svh"

// ----------------------------------------------------------------------------
// HSV to RGB converter
// Streaming fixed-point conversion of one HSV color to 8-bit RGB per beat.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_top import hsv_pkg::*; #(
  parameter int unsigned QueueDepth = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  // [14:0] hue, [22:15] saturation, [30:23] brightness, [31] zero
  input  wire logic [31:0] s_axis_tdata_i,
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // [7:0] red, [15:8] green, [23:16] blue
  output      logic [23:0] m_axis_tdata_o
);

  logic         front_valid, fifo_in_ready;
  hsv_item_t    front_item;
  logic         fifo_valid, back_ready;
  hsv_item_t    fifo_item;
  fifo_status_t fifo_stat;
  logic         fifo_push, fifo_pop;
  logic [7:0]   red, green, blue;

  // Accept and classify
  hsv_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid_i),
    .in_ready_o   (s_axis_tready_o),
    .hue_i        (s_axis_tdata_i[14:0]),
    .saturation_i (s_axis_tdata_i[22:15]),
    .brightness_i (s_axis_tdata_i[30:23]),
    .out_valid_o  (front_valid),
    .out_ready_i  (fifo_in_ready),
    .out_item_o   (front_item)
  );

  // Decouple front end from datapath
  hsv_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (front_valid),
    .in_ready_o  (fifo_in_ready),
    .in_item_i   (front_item),
    .out_valid_o (fifo_valid),
    .out_ready_i (back_ready),
    .out_item_o  (fifo_item),
    .status_o    (fifo_stat)
  );

  // Compute and route channels
  hsv_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (fifo_valid),
    .in_ready_o  (back_ready),
    .in_item_i   (fifo_item),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .red_o       (red),
    .green_o     (green),
    .blue_o      (blue)
  );

  assign m_axis_tdata_o = {blue, green, red};

  assign fifo_push = front_valid && fifo_in_ready;
  assign fifo_pop  = fifo_valid && back_ready;

  // Queue is never written while full
  `HSV_ASSERT(a_fifo_no_overflow, fifo_push |-> !fifo_stat.full)
  // Queue only drains through a pop
  `HSV_ASSERT(a_fifo_empty_by_pop, !fifo_stat.empty |=> !fifo_stat.empty || $past(fifo_pop))
  // Input stalls only when the front register holds a beat
  `HSV_ASSERT_ALWAYS(a_stall_has_item, !s_axis_tready_o |-> front_valid)

endmodule

`default_nettype wire

### test/tb_top.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Streams HSV colors into hsv_to_rgb_converter_top and checks every RGB beat
// against an in-bench fixed-point predictor. Directed tests cover grey, the
// sector bounds and hue wrap. Random phases then vary source gaps and sink
// stalls, including a pause that lets the pipeline drain.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top import hsv_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  // Full hue circle in 1/64 degree units
  localparam int unsigned TurnUnits = 6 * SectorUnits;
  localparam int unsigned HueMax    = 32767;

  // Expected color, packed as on m_axis_tdata_o
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // [14:0] hue, [22:15] saturation, [30:23] brightness, [31] zero
  logic [31:0] s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // [7:0] red, [15:8] green, [23:16] blue
  logic [23:0] m_axis_tdata_o;

  rgb_t expected_colors[$];
  int unsigned mismatch_count = 0;
  int unsigned send_idle_pct  = 0;
  int unsigned sink_stall_pct = 0;

  hsv_to_rgb_converter_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #6ns clk_i = ~clk_i;

  // Compute the RGB color that one HSV beat must produce
  function automatic rgb_t predict_rgb(input logic [14:0] hue, input logic [7:0] sat,
                                       input logic [7:0] val);
    int unsigned h;
    int unsigned s;
    int unsigned v;
    int unsigned f;
    int unsigned p;
    int unsigned q;
    int unsigned t;
    sector_e     sector;
    rgb_t        rgb;
    h = hue;
    s = sat;
    v = val;
    if (s == 0) begin
      rgb = '{blue: val, green: val, red: val};
    end else begin
      // fold hues past the full circle back into 0..359 degrees
      if (h >= TurnUnits) begin
        h = h - TurnUnits;
      end
      sector = sector_e'(h / SectorUnits);
      f = h % SectorUnits;
      p = (v * (UnitMax - s)) / UnitMax;
      q = (v * (FracScale - s * f)) / FracScale;
      t = (v * (FracScale - s * (SectorUnits - f))) / FracScale;
      case (sector)
        SECTOR_0: rgb = '{red: v[7:0], green: t[7:0], blue: p[7:0]};
        SECTOR_1: rgb = '{red: q[7:0], green: v[7:0], blue: p[7:0]};
        SECTOR_2: rgb = '{red: p[7:0], green: v[7:0], blue: t[7:0]};
        SECTOR_3: rgb = '{red: p[7:0], green: q[7:0], blue: v[7:0]};
        SECTOR_4: rgb = '{red: t[7:0], green: p[7:0], blue: v[7:0]};
        default:  rgb = '{red: v[7:0], green: p[7:0], blue: q[7:0]};
      endcase
    end
    return rgb;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Drive one HSV beat, idling first as the current phase asks
  task automatic send_color(input logic [14:0] hue, input logic [7:0] sat,
                            input logic [7:0] val);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tdata_i  <= {1'b0, val, sat, hue};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    expected_colors.insert(expected_colors.size(), predict_rgb(hue, sat, val));
  endtask

  // Pick a random color, biased toward extremes, one hue in five wrapped
  task automatic send_random_color();
    logic [14:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    hue = ($urandom_range(99) < 80) ? 15'($urandom_range(TurnUnits - 1))
                                    : 15'($urandom_range(HueMax, TurnUnits));
    case ($urandom_range(9))
      0:       sat = 8'd0;
      1:       sat = 8'd255;
      default: sat = 8'($urandom_range(255));
    endcase
    case ($urandom_range(9))
      0:       val = 8'd0;
      1:       val = 8'd255;
      default: val = 8'($urandom_range(255));
    endcase
    send_color(hue, sat, val);
  endtask

  // Hold the source until every expected color has come out
  task automatic hold_until_drained();
    s_axis_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (expected_colors.size() != 0);
  endtask

  task automatic test_grey_colors();
    send_color(15'd0, 8'd0, 8'd0);
    send_color(15'd32767, 8'd0, 8'd255);
    send_color(15'd12345, 8'd0, 8'd128);
    send_color(15'd23040, 8'd0, 8'd1);
  endtask

  // First hue of each sector and last hue of sectors 0, 2, 4 and 5, mostly at full saturation and value
  task automatic test_sector_bounds();
    send_color(15'd0, 8'd255, 8'd255);
    send_color(15'd3839, 8'd255, 8'd255);
    send_color(15'd3840, 8'd255, 8'd255);
    send_color(15'd7680, 8'd1, 8'd255);
    send_color(15'd11519, 8'd255, 8'd255);
    send_color(15'd11520, 8'd255, 8'd200);
    send_color(15'd15360, 8'd255, 8'd255);
    send_color(15'd19199, 8'd128, 8'd255);
    send_color(15'd19200, 8'd255, 8'd255);
    send_color(15'd23039, 8'd255, 8'd255);
  endtask

  task automatic test_hue_wrap();
    send_color(15'd23040, 8'd255, 8'd255);
    send_color(15'd32767, 8'd128, 8'd255);
    send_color(15'd27000, 8'd1, 8'd77);
  endtask

  task automatic test_random_phase(input int unsigned count, input int unsigned idle_pct,
                                   input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    sink_stall_pct = stall_pct;
    repeat (count) send_random_color();
  endtask

  // Let the pipeline run dry mid-stream, then resume under stalls
  task automatic test_drain_pause();
    send_idle_pct  = 0;
    sink_stall_pct = 72;
    repeat (30) send_random_color();
    hold_until_drained();
    repeat (30) send_random_color();
  endtask

  // Stall the sink at the rate of the current phase
  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each accepted RGB beat with the oldest expected color
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      rgb_t got;
      rgb_t want;
      got = rgb_t'(m_axis_tdata_o);
      if (expected_colors.size() == 0) begin
        report_mismatch("unexpected beat, red", got.red, -1);
      end else begin
        want = expected_colors.pop_front();
        if (got.red !== want.red) begin
          report_mismatch("red", got.red, want.red);
        end
        if (got.green !== want.green) begin
          report_mismatch("green", got.green, want.green);
        end
        if (got.blue !== want.blue) begin
          report_mismatch("blue", got.blue, want.blue);
        end
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_grey_colors();
    test_sector_bounds();
    test_hue_wrap();
    test_random_phase(270, 0, 0);
    test_random_phase(270, 72, 0);
    test_random_phase(270, 0, 72);
    test_random_phase(270, 19, 19);
    test_drain_pause();

    // Wait out the pipeline, then flag anything still owed
    hold_until_drained();
    repeat (20) @(posedge clk_i);
    foreach (expected_colors[i]) begin
      report_mismatch("missing beat, red", -1, expected_colors[i].red);
    end

    if (mismatch_count == 0) begin
      $display("** hsv_to_rgb_converter_top: PASSED **");
    end else begin
      $display("** hsv_to_rgb_converter_top: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5ms;
    $display("** hsv_to_rgb_converter_top: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
